FILE: rtl/core/bcc_pkg.sv
// Shared types, constants and digit helpers for the BCD clock and calendar core.
package bcc_pkg;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } bcc_op_e;

  // Packed BCD date and time, two digits per byte, four for the year.
  typedef struct packed {
    logic [7:0]  seconds;
    logic [7:0]  minutes;
    logic [7:0]  hours;
    logic [7:0]  day;
    logic [7:0]  month;
    logic [15:0] year;
  } bcc_time_t;

  localparam int unsigned YearDigits = 4;

  localparam logic [3:0] DigitMax     = 4'd9;
  localparam logic [3:0] SecTensMax   = 4'd5;
  localparam logic [4:0] HourTensLim  = 5'd2;
  localparam logic [3:0] HourOnesLim  = 4'd4;
  localparam logic [4:0] DayTensLim   = 5'd3;
  localparam logic [3:0] DayOnesLim   = 4'd1;
  localparam logic [4:0] MonthTensLim = 5'd1;
  localparam logic [3:0] MonthOnesLim = 4'd3;

  function automatic logic [3:0] sat_digit(logic [3:0] d);
    return (d > DigitMax) ? DigitMax : d;
  endfunction

  function automatic logic [7:0] sat_bcd8(logic [7:0] v);
    return {sat_digit(v[7:4]), sat_digit(v[3:0])};
  endfunction

  function automatic logic [15:0] sat_bcd16(logic [15:0] v);
    return {sat_bcd8(v[15:8]), sat_bcd8(v[7:0])};
  endfunction

endpackage

FILE: rtl/core/bcc_if.sv
// Request and response channel interfaces of the BCD clock and calendar core.
interface bcc_req_if;
  logic        valid;
  logic        ready;
  logic [0:0]  operation;
  logic [7:0]  load_seconds;
  logic [7:0]  load_minutes;
  logic [7:0]  load_hours;
  logic [7:0]  load_day;
  logic [7:0]  load_month;
  logic [15:0] load_year;

  modport source (
    output valid, operation, load_seconds, load_minutes, load_hours,
           load_day, load_month, load_year,
    input  ready
  );
  modport sink (
    input  valid, operation, load_seconds, load_minutes, load_hours,
           load_day, load_month, load_year,
    output ready
  );
endinterface

interface bcc_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  seconds_now;
  logic [7:0]  minutes_now;
  logic [7:0]  hours_now;
  logic [7:0]  day_now;
  logic [7:0]  month_now;
  logic [15:0] year_now;

  modport source (
    output valid, seconds_now, minutes_now, hours_now, day_now, month_now,
           year_now,
    input  ready
  );
  modport sink (
    input  valid, seconds_now, minutes_now, hours_now, day_now, month_now,
           year_now,
    output ready
  );
endinterface

FILE: rtl/core/bcc_tick_logic.sv
// One-second advance of the date and time with carries up to the year.
module bcc_tick_logic (
  input  bcc_pkg::bcc_time_t cur_i,
  output bcc_pkg::bcc_time_t nxt_o
);
  import bcc_pkg::*;

  always_comb begin : tick_comb
    logic [3:0]  s0, s1, m0, m1, h0, d0, n0, dg;
    logic [4:0]  h1, d1, n1;
    logic        cm, ch, cd, cn, cy, carry;
    logic [15:0] y;

    s0 = cur_i.seconds[3:0];
    s1 = cur_i.seconds[7:4];
    m0 = cur_i.minutes[3:0];
    m1 = cur_i.minutes[7:4];
    h0 = cur_i.hours[3:0];
    h1 = {1'b0, cur_i.hours[7:4]};
    d0 = cur_i.day[3:0];
    d1 = {1'b0, cur_i.day[7:4]};
    n0 = cur_i.month[3:0];
    n1 = {1'b0, cur_i.month[7:4]};
    cm = 1'b0;
    ch = 1'b0;
    cd = 1'b0;
    cn = 1'b0;
    cy = 1'b0;
    y  = '0;

    // seconds: a tens digit of five or more wraps and carries
    if (s0 >= DigitMax) begin
      s0 = '0;
      if (s1 >= SecTensMax) begin
        s1 = '0;
        cm = 1'b1;
      end else begin
        s1 = s1 + 4'd1;
      end
    end else begin
      s0 = s0 + 4'd1;
    end

    if (cm) begin
      if (m0 >= DigitMax) begin
        m0 = '0;
        if (m1 >= SecTensMax) begin
          m1 = '0;
          ch = 1'b1;
        end else begin
          m1 = m1 + 4'd1;
        end
      end else begin
        m0 = m0 + 4'd1;
      end
    end

    if (ch) begin
      if (h0 >= DigitMax) begin
        h0 = '0;
        h1 = h1 + 5'd1;
      end else begin
        h0 = h0 + 4'd1;
      end
    end

    // hours of 24 or more: clear the time and roll the day
    if (h1 > HourTensLim || (h1 == HourTensLim && h0 >= HourOnesLim)) begin
      s0 = '0;
      s1 = '0;
      m0 = '0;
      m1 = '0;
      h0 = '0;
      h1 = '0;
      cd = 1'b1;
    end

    if (cd) begin
      if (d0 >= DigitMax) begin
        d0 = '0;
        d1 = d1 + 5'd1;
      end else begin
        d0 = d0 + 4'd1;
      end
    end

    // every month has thirty days
    if (d1 > DayTensLim || (d1 == DayTensLim && d0 >= DayOnesLim)) begin
      d1 = '0;
      d0 = 4'd1;
      cn = 1'b1;
    end

    if (cn) begin
      if (n0 >= DigitMax) begin
        n0 = '0;
        n1 = n1 + 5'd1;
      end else begin
        n0 = n0 + 4'd1;
      end
    end

    // month of 13 or more: back to 01 and carry into the year
    if (n1 > MonthTensLim || (n1 == MonthTensLim && n0 >= MonthOnesLim)) begin
      n1 = '0;
      n0 = 4'd1;
      cy = 1'b1;
    end

    // year counts in decimal and wraps from 9999 to 0000
    carry = cy;
    for (int k = 0; k < YearDigits; k++) begin
      dg = cur_i.year[4*k +: 4];
      if (carry) begin
        if (dg >= DigitMax) begin
          dg = '0;
        end else begin
          dg    = dg + 4'd1;
          carry = 1'b0;
        end
      end
      y[4*k +: 4] = dg;
    end

    nxt_o.seconds = {s1, s0};
    nxt_o.minutes = {m1, m0};
    nxt_o.hours   = {h1[3:0], h0};
    nxt_o.day     = {d1[3:0], d0};
    nxt_o.month   = {n1[3:0], n0};
    nxt_o.year    = y;
  end

endmodule

FILE: rtl/core/bcd_clock_calendar_tick_core.sv
// Top level of the BCD clock and calendar: request stage, state and response register.
//
// The core keeps a 24-hour time and a date (30-day months, 12 months, four-digit
// year wrapping at 9999) as packed BCD. Each request is either a one-second tick or
// a load of all fields (digits above nine saturate to nine); each request yields
// exactly one response with the full date and time after that request. Throughput
// is one request per cycle while responses are taken. A request is held in the request
// register, then the tick logic and load select feed the state and the response
// register at once, so the next request sees the updated state with no gap. The
// response register decouples the sides: the core keeps taking a request while a
// response waits, and stalls only when both the request stage and the response
// register are full. After reset the state reads 00:00:00, day 00, month 00, year
// 0000; day and month of 00 count up to 01 on their next carry.
module bcd_clock_calendar_tick_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  bcc_req_if.sink   req_i,
  bcc_rsp_if.source rsp_o
);
  import bcc_pkg::*;

  logic      req_valid_q;
  bcc_op_e   op_q;
  bcc_time_t load_q;
  logic      rsp_valid_q;
  bcc_time_t rsp_q;
  bcc_time_t state_q, state_d;
  bcc_time_t tick_nxt;
  logic      step_en;
  logic      req_fire;

  // advance the held request whenever the response register frees up
  assign step_en      = req_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready  = !req_valid_q || step_en;
  assign req_fire     = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        req_valid_q <= req_i.valid;
      end
      if (step_en) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // capture the request; saturate load digits here to keep the step path short
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      op_q           <= bcc_op_e'(req_i.operation);
      load_q.seconds <= sat_bcd8(req_i.load_seconds);
      load_q.minutes <= sat_bcd8(req_i.load_minutes);
      load_q.hours   <= sat_bcd8(req_i.load_hours);
      load_q.day     <= sat_bcd8(req_i.load_day);
      load_q.month   <= sat_bcd8(req_i.load_month);
      load_q.year    <= sat_bcd16(req_i.load_year);
    end
  end

  bcc_tick_logic u_tick (
    .cur_i (state_q),
    .nxt_o (tick_nxt)
  );

  assign state_d = (op_q == OP_LOAD) ? load_q : tick_nxt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (step_en) begin
      state_q <= state_d;
    end
  end

  // response payload mirrors the state written in the same step
  always_ff @(posedge clk_i) begin
    if (step_en) begin
      rsp_q <= state_d;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.seconds_now = rsp_q.seconds;
  assign rsp_o.minutes_now = rsp_q.minutes;
  assign rsp_o.hours_now   = rsp_q.hours;
  assign rsp_o.day_now     = rsp_q.day;
  assign rsp_o.month_now   = rsp_q.month;
  assign rsp_o.year_now    = rsp_q.year;

  // a tick always leaves hours, day and month inside their ranges
  a_tick_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_en && op_q == OP_TICK) |=>
      (rsp_o.hours_now <= 8'h23 && rsp_o.day_now <= 8'h30 && rsp_o.month_now <= 8'h12))
    else $error("tick result out of range");

  // a pending response always matches the stored date and time
  a_rsp_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_q == state_q))
    else $error("response differs from state");

  // a load never stores a year digit above nine
  a_load_year_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_en && op_q == OP_LOAD) |=>
      (rsp_o.year_now[15:12] <= 4'd9 && rsp_o.year_now[11:8] <= 4'd9 &&
       rsp_o.year_now[7:4] <= 4'd9 && rsp_o.year_now[3:0] <= 4'd9))
    else $error("loaded year digit not saturated");

endmodule
